// ===== hw/rtl/aspnf_pkg.sv =====
// Package for the aging slot pool with next-fit allocation.
// Holds the field widths, constants, codes and the controller/datapath interface types.
// No dependencies.
package aspnf_pkg;

  localparam int ACT_W     = 7;
  localparam int RATE_W    = 16;
  localparam int TICK_W    = 16;
  localparam int LIFE_W    = 16;
  localparam int SLOT_W    = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;
  localparam int PROD_W    = RATE_W + TICK_W;
  localparam int DECAY_SHIFT = 9;
  localparam int DEC_W     = PROD_W - DECAY_SHIFT;

  localparam logic [LIFE_W-1:0] LIFE_ONE   = 16'h8000;
  localparam logic [ACT_W-1:0]  ACT_RESET  = 7'd64;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 1'b1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DECAY  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic scan;
    logic decay;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic found;
    logic last;
    logic res_busy;
  } dp_sts_t;

endpackage

// ===== hw/rtl/aging_slot_pool_next_fit_unit.sv =====
// Top level of the aging slot pool with next-fit allocation.
// Depends on aspnf_pkg, aspnf_ctrl and aspnf_dp (which holds aspnf_ram).
//
// Channel   Signals                                    Direction
// request   req_valid, req_ready, mode, tick_time      in
// result    res_valid, res_ready, slot, pool_full      out
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  in
//
// An allocate request scans slots until a free slot is found or n slots are checked,
// then commits its result; a tick request decays n slots, where n is the effective
// active count. The life memory reads one slot per cycle.
// After reset a clearing pass writes zero to all MAX_SLOTS slots before the first
// request is taken. A finished result waits in an output register, and a new request
// is accepted while it waits; a later result stalls until that register is free.
// Configuration writes are taken every cycle.
module aging_slot_pool_next_fit_unit
  import aspnf_pkg::*;
#(
  parameter int MAX_SLOTS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic                 mode,
  input  logic [TICK_W-1:0]    tick_time,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [SLOT_W-1:0]    slot,
  output logic                 pool_full,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  state_t  state;

  assign cfg_ready = 1'b1;

  aspnf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .mode     (mode),
    .sts      (sts),
    .req_ready(req_ready),
    .cmd      (cmd),
    .state    (state)
  );

  aspnf_dp #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .mode     (mode),
    .tick_time(tick_time),
    .cmd      (cmd),
    .sts      (sts),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .slot     (slot),
    .pool_full(pool_full)
  );

  a_full_is_slot_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && pool_full |-> slot == '0)
    else $error("A full pool result does not name slot zero.");

  a_alloc_starts_scan: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (mode == MODE_ALLOC) |=> state == ST_SCAN)
    else $error("An accepted allocate request did not start a scan.");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_FINISH))
    else $error("A result appeared without a commit.");

endmodule

// ===== hw/rtl/aspnf_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module aspnf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/aspnf_ctrl.sv =====
// Controller state machine for the slot pool: clearing pass, scan, decay and result commit.
// Depends on aspnf_pkg.
module aspnf_ctrl
  import aspnf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  input  logic    mode,
  input  dp_sts_t sts,
  output logic    req_ready,
  output dp_cmd_t cmd,
  output state_t  state
);

  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = (mode == MODE_TICK) ? ST_DECAY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found || sts.last) begin
          state_next = ST_FINISH;
        end
      end
      ST_DECAY: begin
        cmd.decay = 1'b1;
        if (sts.last) begin
          state_next = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (!sts.res_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== hw/rtl/aspnf_dp.sv =====
// Datapath for the slot pool: configuration registers, life memory, scan pointer,
// decay arithmetic and the result register. Depends on aspnf_pkg and aspnf_ram.
module aspnf_dp
  import aspnf_pkg::*;
#(
  parameter int MAX_SLOTS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 mode,
  input  logic [TICK_W-1:0]    tick_time,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [SLOT_W-1:0]    slot,
  output logic                 pool_full
);

  localparam int HW = $clog2(MAX_SLOTS);
  localparam int NW = $clog2(MAX_SLOTS + 1);
  localparam int CW = (NW > ACT_W) ? NW : ACT_W;

  logic [ACT_W-1:0]  active_slots;
  logic [RATE_W-1:0] decay_rate;
  logic [HW-1:0]     hint;
  logic [HW-1:0]     ptr;
  logic              rd_vld;
  logic [PROD_W-1:0] prod;
  logic [NW-1:0]     n_eff;
  logic [HW-1:0]     chk_addr;
  logic [NW-1:0]     chk_cnt;
  logic [HW-1:0]     fin_addr;
  logic              fin_full;

  logic [CW-1:0]      act_ext;
  logic [NW-1:0]      n_cur;
  logic [NW-1:0]      ptr_p1;
  logic [HW-1:0]      ptr_wrap;
  logic [PROD_W-1:0]  prod_cur;
  logic [DEC_W-1:0]   dec;
  logic [LIFE_W-1:0]  rdata;
  logic [LIFE_W-1:0]  new_life;
  logic               ram_we;
  logic [HW-1:0]      ram_waddr;
  logic [LIFE_W-1:0]  ram_wdata;
  logic [SLOT_W+HW-1:0] fin_wide;

  assign act_ext = CW'(active_slots);

  always_comb begin
    if (act_ext == '0) begin
      n_cur = NW'(1);
    end else if (act_ext > CW'(MAX_SLOTS)) begin
      n_cur = NW'(MAX_SLOTS);
    end else begin
      n_cur = NW'(act_ext);
    end
  end

  assign ptr_p1   = NW'(ptr) + NW'(1);
  assign ptr_wrap = (ptr_p1 == n_eff) ? '0 : HW'(ptr_p1);
  assign prod_cur = PROD_W'(decay_rate) * PROD_W'(tick_time);
  assign dec      = prod[PROD_W-1:DECAY_SHIFT];
  assign new_life = (DEC_W'(rdata) > dec) ? (rdata - dec[LIFE_W-1:0]) : '0;
  assign fin_wide = {{SLOT_W{1'b0}}, fin_addr};

  assign sts.clr_last = (ptr == HW'(MAX_SLOTS - 1));
  assign sts.found    = rd_vld && (rdata == '0);
  assign sts.last     = rd_vld && (chk_cnt == (n_eff - NW'(1)));
  assign sts.res_busy = res_valid && !res_ready;

  always_comb begin
    ram_we    = cmd.clr || (cmd.decay && rd_vld) || cmd.commit;
    ram_waddr = chk_addr;
    ram_wdata = new_life;
    if (cmd.clr) begin
      ram_waddr = ptr;
      ram_wdata = '0;
    end else if (cmd.commit) begin
      ram_waddr = fin_addr;
      ram_wdata = LIFE_ONE;
    end
  end

  aspnf_ram #(
    .WIDTH(LIFE_W),
    .DEPTH(MAX_SLOTS)
  ) u_life_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ptr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= ACT_RESET;
      decay_rate   <= RATE_RESET;
      hint         <= '0;
      ptr          <= '0;
      rd_vld       <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ACTIVE: active_slots <= cfg_data[ACT_W-1:0];
          CFG_DECAY:  decay_rate   <= cfg_data[RATE_W-1:0];
          default:    active_slots <= active_slots;
        endcase
      end
      rd_vld <= cmd.scan || cmd.decay;
      if (cmd.clr) begin
        ptr <= ptr + HW'(1);
      end else if (cmd.load) begin
        ptr <= ((mode == MODE_ALLOC) && (NW'(hint) < n_cur)) ? hint : '0;
      end else if (cmd.scan || cmd.decay) begin
        ptr <= ptr_wrap;
      end
      if (cmd.commit && !fin_full) begin
        hint <= fin_addr;
      end
      if (cmd.commit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod    <= prod_cur;
      n_eff   <= n_cur;
      chk_cnt <= '0;
    end else if ((cmd.scan || cmd.decay) && rd_vld) begin
      chk_cnt <= chk_cnt + NW'(1);
    end
    if (cmd.scan || cmd.decay) begin
      chk_addr <= ptr;
    end
    if (cmd.scan && sts.found) begin
      fin_addr <= chk_addr;
      fin_full <= 1'b0;
    end else if (cmd.scan && sts.last) begin
      fin_addr <= '0;
      fin_full <= 1'b1;
    end
    if (cmd.commit) begin
      slot      <= fin_wide[SLOT_W-1:0];
      pool_full <= fin_full;
    end
  end

endmodule
